// ----- rtl/core/prc_pkg.sv -----
package prc_pkg;

  localparam int unsigned DEF_MAX_NAT_LEN = 20;
  localparam int unsigned DEF_MAX_RF_LEN  = 25;
  localparam int unsigned MIN_NAT_LEN     = 4;
  localparam int unsigned MIN_RF_LEN      = 5;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned LEN_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_F = 8'h46;

  // Contribution of "R", "F" and the check pair to the mod 97 sum, by the
  // number of extra digits the check pair adds (two, three or four in total).
  localparam logic [6:0] RF_TAIL_D2 = 7'((2715 * 100) % 97);
  localparam logic [6:0] RF_TAIL_D3 = 7'((2715 * 1000) % 97);
  localparam logic [6:0] RF_TAIL_D4 = 7'((2715 * 10000) % 97);
  localparam logic [6:0] RF_MULT_D2 = 7'((10 ** 6) % 97);
  localparam logic [6:0] RF_MULT_D3 = 7'((10 ** 7) % 97);
  localparam logic [6:0] RF_MULT_D4 = 7'((10 ** 8) % 97);

  localparam int unsigned MOD97_RECIP = 10810;  // floor(2**20 / 97)
  localparam int unsigned MOD10_RECIP = 6553;   // floor(2**16 / 10)

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             rf;
    logic             bad;
    logic [5:0]       cp0;
    logic [6:0]       rem;
    logic [6:0]       tail;
    logic [6:0]       mult;
    logic [2:0][7:0]  psum;
    logic [3:0]       held;
    logic [1:0]       ph;
  } prc_state_t;

  typedef struct packed {
    logic             kind_rf;
    logic             bad;
    logic [LEN_W-1:0] len;
    logic [6:0]       rem;
    logic [6:0]       tail;
    logic [6:0]       mult;
    logic [2:0][7:0]  psum;
    logic [3:0]       held;
    logic [1:0]       ph;
  } prc_snap_t;

  function automatic logic [6:0] mod97(input logic [13:0] x);
    logic [27:0] prod;
    logic [7:0]  q;
    logic [13:0] qm;
    logic [7:0]  r;
    prod = 28'(x) * 28'(MOD97_RECIP);
    q    = prod[27:20];
    qm   = 14'(q) * 14'd97;
    r    = 8'(x - qm);
    if (r >= 8'd97) begin
      r = r - 8'd97;
    end
    return r[6:0];
  endfunction

  function automatic logic [3:0] mod10(input logic [11:0] x);
    logic [24:0] prod;
    logic [8:0]  q;
    logic [11:0] qm;
    logic [4:0]  r;
    prod = 25'(x) * 25'(MOD10_RECIP);
    q    = prod[24:16];
    qm   = 12'(q) * 12'd10;
    r    = 5'(x - qm);
    if (r >= 5'd10) begin
      r = r - 5'd10;
    end
    return r[3:0];
  endfunction

endpackage

// ----- rtl/core/prc_update.sv -----
module prc_update (
  input  prc_pkg::prc_state_t st,
  input  logic [7:0]          char_code,
  output prc_pkg::prc_state_t st_next,
  output prc_pkg::prc_snap_t  snap
);
  import prc_pkg::*;

  logic        dig;
  logic        upper;
  logic        lower;
  logic        alnum;
  logic [5:0]  val;
  logic        wide;
  logic [13:0] push_sum;
  logic [1:0]  dsum;
  logic [6:0]  tail_base;
  logic [6:0]  mult_sel;
  logic [11:0] tail_sum;
  logic [1:0]  pidx;
  logic [4:0]  idx;

  assign idx   = st.cnt;
  assign dig   = char_code inside {[8'h30:8'h39]};
  assign upper = char_code inside {[8'h41:8'h5a]};
  assign lower = char_code inside {[8'h61:8'h7a]};
  assign alnum = dig || upper || lower;

  always_comb begin
    if (dig) begin
      val = 6'(char_code - 8'h30);
    end else if (upper) begin
      val = 6'(char_code - 8'h41 + 8'd10);
    end else if (lower) begin
      val = 6'(char_code - 8'h61 + 8'd10);
    end else begin
      val = '0;
    end
  end

  // letters enter the mod 97 sum as two digits
  assign wide     = val >= 6'd10;
  assign push_sum = 14'(st.rem) * (wide ? 14'd100 : 14'd10) + 14'(val);
  assign dsum     = 2'(st.cp0 >= 6'd10) + 2'(wide);

  always_comb begin
    case (dsum)
      2'd0: begin
        tail_base = RF_TAIL_D2;
        mult_sel  = RF_MULT_D2;
      end
      2'd1: begin
        tail_base = RF_TAIL_D3;
        mult_sel  = RF_MULT_D3;
      end
      default: begin
        tail_base = RF_TAIL_D4;
        mult_sel  = RF_MULT_D4;
      end
    endcase
  end

  assign tail_sum = 12'(tail_base) + 12'(st.cp0) * (wide ? 12'd100 : 12'd10) + 12'(val);

  // digit before this one joins phase group (idx - 1) mod 3
  always_comb begin
    case (st.ph)
      2'd0:    pidx = 2'd2;
      2'd1:    pidx = 2'd0;
      default: pidx = 2'd1;
    endcase
  end

  always_comb begin
    st_next = st;
    if (idx == 5'd0) begin
      if (char_code == CHAR_R) begin
        st_next.rf = 1'b1;
      end else if (!dig) begin
        st_next.bad = 1'b1;
      end
    end else if (idx == 5'd1) begin
      if (st.rf) begin
        if (char_code != CHAR_F) begin
          st_next.rf  = 1'b0;
          st_next.bad = 1'b1;
        end
      end else if (!dig) begin
        st_next.bad = 1'b1;
      end
    end else if (st.rf) begin
      if (!alnum) begin
        st_next.bad = 1'b1;
      end
      if (idx == 5'd2) begin
        st_next.cp0 = val;
      end else if (idx == 5'd3) begin
        st_next.tail = mod97(14'(tail_sum));
        st_next.mult = mult_sel;
      end else begin
        st_next.rem = mod97(push_sum);
      end
    end else if (!dig) begin
      st_next.bad = 1'b1;
    end

    if (idx != 5'd0) begin
      st_next.psum[pidx] = st.psum[pidx] + 8'(st.held);
    end
    st_next.held = dig ? 4'(char_code - 8'h30) : 4'd0;
    if (st.cnt != CNT_MAX) begin
      st_next.cnt = st.cnt + 1'b1;
      st_next.ph  = (st.ph == 2'd2) ? 2'd0 : st.ph + 2'd1;
    end
  end

  always_comb begin
    snap.kind_rf = (idx != 5'd0) && st_next.rf;
    snap.bad     = st_next.bad;
    snap.len     = LEN_W'(idx) + 1'b1;
    snap.rem     = st_next.rem;
    snap.tail    = st_next.tail;
    snap.mult    = st_next.mult;
    snap.psum    = st_next.psum;
    snap.held    = st_next.held;
    snap.ph      = st.ph;
  end

endmodule

// ----- rtl/core/prc_verdict.sv -----
module prc_verdict #(
  parameter int unsigned MAX_NATIONAL_LEN = prc_pkg::DEF_MAX_NAT_LEN,
  parameter int unsigned MAX_RF_LEN       = prc_pkg::DEF_MAX_RF_LEN
) (
  input  prc_pkg::prc_snap_t snap,
  output logic               is_valid
);
  import prc_pkg::*;

  logic [6:0]  rf_rem;
  logic        rf_len_ok;
  logic        nat_len_ok;
  logic [11:0] wsum;
  logic [3:0]  wmod;
  logic [3:0]  chk;
  logic [1:0]  j0;
  logic [1:0]  j1;
  logic [1:0]  j2;

  function automatic logic [2:0] weight(input logic [1:0] j);
    case (j)
      2'd0:    return 3'd7;
      2'd1:    return 3'd3;
      default: return 3'd1;
    endcase
  endfunction

  assign rf_rem = mod97(14'(snap.rem) * 14'(snap.mult) + 14'(snap.tail));

  assign rf_len_ok  = (snap.len >= LEN_W'(MIN_RF_LEN)) && (snap.len <= LEN_W'(MAX_RF_LEN));
  assign nat_len_ok = (snap.len >= LEN_W'(MIN_NAT_LEN)) &&
                      (snap.len <= LEN_W'(MAX_NATIONAL_LEN));

  // weight index of group p is (n + 2 - p) mod 3, n mod 3 = ph
  always_comb begin
    case (snap.ph)
      2'd0: begin
        j0 = 2'd2;
        j1 = 2'd1;
        j2 = 2'd0;
      end
      2'd1: begin
        j0 = 2'd0;
        j1 = 2'd2;
        j2 = 2'd1;
      end
      default: begin
        j0 = 2'd1;
        j1 = 2'd0;
        j2 = 2'd2;
      end
    endcase
  end

  assign wsum = 12'(snap.psum[0]) * 12'(weight(j0)) +
                12'(snap.psum[1]) * 12'(weight(j1)) +
                12'(snap.psum[2]) * 12'(weight(j2));
  assign wmod = mod10(wsum);
  assign chk  = (wmod == 4'd0) ? 4'd0 : 4'd10 - wmod;

  always_comb begin
    if (snap.kind_rf) begin
      is_valid = !snap.bad && rf_len_ok && (rf_rem == 7'd1);
    end else begin
      is_valid = !snap.bad && nat_len_ok && (chk == snap.held);
    end
  end

endmodule

// ----- rtl/core/payment_reference_check.sv -----
// Payment reference checker: one ASCII character per item, result on the last one.
// Path: after the last character is accepted, the result item is built in order (accept into the
// input register, state update into the verdict register, check into the output register).
// Throughput: one character per cycle, but a last character waits while the verdict register is
// full and cannot move on; the input side keeps taking other items while a result waits.
// Reset (rst, synchronous, active high) empties all stages and clears the reference state.
module payment_reference_check #(
  parameter int unsigned MAX_NATIONAL_LEN = prc_pkg::DEF_MAX_NAT_LEN,
  parameter int unsigned MAX_RF_LEN       = prc_pkg::DEF_MAX_RF_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] is_valid, [7:1] zero
  output logic       m_axis_tuser    // ref_kind (1 = RF creditor reference)
);
  import prc_pkg::*;

  // input register
  logic       in_v;
  logic [7:0] in_char;
  logic       in_last;
  logic       in_go;

  // per-reference running state
  prc_state_t st;
  prc_state_t st_next;

  // snapshot of the finished reference, waiting for the final check
  prc_snap_t  snap_next;
  prc_snap_t  sn;
  logic       sn_v;
  logic       sn_go;
  logic       sn_free;
  logic       verdict;

  // output register
  logic       out_v;
  logic       out_valid_bit;
  logic       out_kind;

  // Advance each stage when the one after it is empty or moving this cycle.
  // A character that is not the last never needs room downstream.
  assign sn_go         = sn_v && (!out_v || m_axis_tready);
  assign sn_free       = !sn_v || sn_go;
  assign in_go         = in_v && (!in_last || sn_free);
  assign s_axis_tready = !in_v || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  prc_update u_update (
    .st        (st),
    .char_code (in_char),
    .st_next   (st_next),
    .snap      (snap_next)
  );

  // Clear the running state after the last character so the next reference starts fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_go) begin
      st <= in_last ? '0 : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_v <= 1'b0;
    end else if (in_go && in_last) begin
      sn_v <= 1'b1;
    end else if (sn_go) begin
      sn_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) begin
      sn <= snap_next;
    end
  end

  prc_verdict #(
    .MAX_NATIONAL_LEN (MAX_NATIONAL_LEN),
    .MAX_RF_LEN       (MAX_RF_LEN)
  ) u_verdict (
    .snap     (sn),
    .is_valid (verdict)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (sn_go) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sn_go) begin
      out_valid_bit <= verdict;
      out_kind      <= sn.kind_rf;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'd0, out_valid_bit};
  assign m_axis_tuser  = out_kind;

`ifndef SYNTHESIS
  // a finished reference only comes from a last character
  a_snap_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(sn_v) |-> $past(in_go && in_last))
    else $error("verdict stage loaded without a last character");

  // state is cleared after the last character
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_go && in_last) |=> (st.cnt == '0 && !st.rf && !st.bad && st.rem == '0))
    else $error("reference state not cleared after last character");

  // an RF kind needs at least the two prefix characters
  a_rf_len: assert property (@(posedge clk) disable iff (rst)
    (sn_v && sn.kind_rf) |-> (sn.len >= LEN_W'(2)))
    else $error("RF kind flagged on a reference shorter than its prefix");
`endif

endmodule
